### src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define AVR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Equality of two expressions checked at every clock edge outside reset.
`define AVR_ASSERT_EQ(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) == (rhs)) \
    else $error(msg);

`endif

### src/avr_pkg.sv
// Package with widths, lane codes and types of the vector alignment rotation block.
`default_nettype none

package avr_pkg;

  localparam int IN_W    = 16;
  localparam int OUT_W   = 16;
  localparam int PROD_W  = 32;
  localparam int V_W     = 33;
  localparam int D_W     = 33;
  localparam int DU_W    = 32;
  localparam int VS_W    = 19;
  localparam int VQ_W    = 26;
  localparam int SQ_W    = 50;
  localparam int NUM_W   = 51;
  localparam int MAG_W   = 50;
  localparam int REM_W   = 52;
  localparam int Q_W     = 20;
  localparam int QS_W    = Q_W + 1;
  localparam int DIV_STEPS = Q_W + 1;
  localparam int THR_W   = 15;
  localparam int FRAC_W  = 14;
  localparam int LANES   = 6;

  localparam int L00 = 0;
  localparam int L11 = 1;
  localparam int L22 = 2;
  localparam int L01 = 3;
  localparam int L02 = 4;
  localparam int L12 = 5;

  localparam int FRONT_STAGES = 6;
  localparam int DIV_STAGES   = DIV_STEPS + 2;
  localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + 1;

  localparam int ONE_Q14 = 1 << FRAC_W;
  localparam int ONE_Q28 = 1 << (2 * FRAC_W);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(16);

  typedef logic signed [IN_W-1:0]  q14_t;
  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic signed [QS_W-1:0]  quo_t;
  typedef logic signed [VS_W-1:0]  skew_t;

  typedef struct packed {
    logic  singular;
    skew_t vs0;
    skew_t vs1;
    skew_t vs2;
  } side_t;

endpackage

`default_nettype wire

### src/align_vector_rotation.sv
// Top level of the rotation that turns one unit vector onto another.
//
//   channel   ports                                   handshake
//   input     from_x from_y from_z to_x to_y to_z     start, taken when busy is low
//   result    m00 .. m22, singular                    done, one cycle, no back-pressure
//   config    cfg_data (singular_threshold)           cfg_we, written at once
//
// One item is accepted in every cycle outside reset; its result appears with done.
// The divider resolves one quotient bit per stage over 21 stages, behind
// six product and rounding stages of the front pipeline.
// Reset is synchronous; busy is high during reset and low otherwise.
// Nothing stalls: the pipeline advances every cycle and done cannot be held off.
`default_nettype none
`include "assert_macros.svh"

module align_vector_rotation import avr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  q14_t             from_x,
  input  q14_t             from_y,
  input  q14_t             from_z,
  input  q14_t             to_x,
  input  q14_t             to_y,
  input  q14_t             to_z,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_data,
  output logic             done,
  output q14_t             m00,
  output q14_t             m01,
  output q14_t             m02,
  output q14_t             m10,
  output q14_t             m11,
  output q14_t             m12,
  output q14_t             m20,
  output q14_t             m21,
  output q14_t             m22,
  output logic             singular
);

  localparam int E_W     = 23;
  localparam int SAT_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int SAT_MIN = -(1 << (OUT_W - 1));

  function automatic q14_t sat16(input logic signed [E_W-1:0] x);
    if (x > E_W'(SAT_MAX)) begin
      return OUT_W'(SAT_MAX);
    end else if (x < E_W'(SAT_MIN)) begin
      return OUT_W'(SAT_MIN);
    end else begin
      return OUT_W'(x);
    end
  endfunction

  logic [THR_W-1:0] thr;
  logic             accept;

  q14_t a_in [3];
  q14_t b_in [3];

  logic            f_valid;
  num_t            f_num [LANES];
  logic [DU_W-1:0] f_d;
  side_t           f_side;

  logic  q_valid;
  quo_t  q [LANES];
  side_t q_side;

  logic signed [E_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;

  logic ident_out;
  logic diag_ok;

  assign busy   = rst;
  assign accept = start && !busy;

  assign a_in[0] = from_x;
  assign a_in[1] = from_y;
  assign a_in[2] = from_z;
  assign b_in[0] = to_x;
  assign b_in[1] = to_y;
  assign b_in[2] = to_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  avr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .a         (a_in),
    .b         (b_in),
    .thr       (thr),
    .out_valid (f_valid),
    .num       (f_num),
    .d         (f_d),
    .side      (f_side)
  );

  avr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .num       (f_num),
    .d         (f_d),
    .side_in   (f_side),
    .out_valid (q_valid),
    .q         (q),
    .side_out  (q_side)
  );

  always_comb begin
    e00 = E_W'(ONE_Q14) + E_W'(q[L00]);
    e11 = E_W'(ONE_Q14) + E_W'(q[L11]);
    e22 = E_W'(ONE_Q14) + E_W'(q[L22]);
    e01 = E_W'(q[L01]) - E_W'(q_side.vs2);
    e10 = E_W'(q[L01]) + E_W'(q_side.vs2);
    e02 = E_W'(q[L02]) + E_W'(q_side.vs1);
    e20 = E_W'(q[L02]) - E_W'(q_side.vs1);
    e12 = E_W'(q[L12]) - E_W'(q_side.vs0);
    e21 = E_W'(q[L12]) + E_W'(q_side.vs0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_valid;
    end

    singular <= q_side.singular;
    if (q_side.singular) begin
      m00 <= OUT_W'(ONE_Q14);
      m01 <= '0;
      m02 <= '0;
      m10 <= '0;
      m11 <= OUT_W'(ONE_Q14);
      m12 <= '0;
      m20 <= '0;
      m21 <= '0;
      m22 <= OUT_W'(ONE_Q14);
    end else begin
      m00 <= sat16(e00);
      m01 <= sat16(e01);
      m02 <= sat16(e02);
      m10 <= sat16(e10);
      m11 <= sat16(e11);
      m12 <= sat16(e12);
      m20 <= sat16(e20);
      m21 <= sat16(e21);
      m22 <= sat16(e22);
    end
  end

  assign ident_out = (m00 == OUT_W'(ONE_Q14)) && (m11 == OUT_W'(ONE_Q14)) &&
                     (m22 == OUT_W'(ONE_Q14)) && (m01 == '0) && (m02 == '0) &&
                     (m10 == '0) && (m12 == '0) && (m20 == '0) && (m21 == '0);
  assign diag_ok   = (m00 <= OUT_W'(ONE_Q14)) && (m11 <= OUT_W'(ONE_Q14)) &&
                     (m22 <= OUT_W'(ONE_Q14));

  // Every accepted item yields exactly one result after the fixed latency.
  `AVR_ASSERT_EQ(a_latency, clk, rst, done, $past(accept, LATENCY), "result count mismatch")

  // A singular result carries the identity matrix.
  `AVR_ASSERT_IMP(a_identity, clk, rst, done && singular, ident_out, "singular result is not identity")

  // The quadratic term never raises a diagonal entry above one.
  `AVR_ASSERT_IMP(a_diag, clk, rst, done && !singular, diag_ok, "diagonal entry above one")

endmodule

`default_nettype wire

### src/avr_front.sv
// Front pipeline: cross and dot products, rounding, singular test and quadratic numerators.
`default_nettype none

module avr_front import avr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  q14_t             a [3],
  input  q14_t             b [3],
  input  logic [THR_W-1:0] thr,
  output logic             out_valid,
  output num_t             num [LANES],
  output logic [DU_W-1:0]  d,
  output side_t            side
);

  localparam int VQ_FRAC  = 21;
  localparam int VQ_SHIFT = 2 * FRAC_W - VQ_FRAC;
  localparam int VS_SHIFT = FRAC_W;

  function automatic logic signed [V_W-1:0] rnd_shift(input logic signed [V_W-1:0] x,
                                                      input int s);
    logic [V_W-1:0] mag;
    logic [V_W-1:0] r;
    mag = x[V_W-1] ? V_W'(-x) : V_W'(x);
    r = (mag + (V_W'(1) << (s - 1))) >> s;
    return x[V_W-1] ? -$signed(r) : $signed(r);
  endfunction

  logic [FRONT_STAGES-1:0] vld;

  q14_t a_r [3];
  q14_t b_r [3];

  logic signed [PROD_W-1:0] ab [3][3];

  logic signed [V_W-1:0] v [3];
  logic signed [D_W-1:0] dd;

  logic signed [VQ_W-1:0] vq [3];
  logic [DU_W-1:0] d4;
  side_t s4;

  logic signed [SQ_W-1:0] sq [3];
  logic signed [SQ_W-1:0] xp01;
  logic signed [SQ_W-1:0] xp02;
  logic signed [SQ_W-1:0] xp12;
  logic [DU_W-1:0] d5;
  side_t s5;

  logic signed [D_W-1:0] thr_q28;
  logic sing_next;

  assign thr_q28   = $signed(D_W'(thr) << FRAC_W);
  assign sing_next = dd[D_W-1] || (dd == '0) || (dd < thr_q28);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_STAGES-2:0], in_valid};
    end

    for (int i = 0; i < 3; i++) begin
      a_r[i] <= a[i];
      b_r[i] <= b[i];
    end

    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ab[i][j] <= PROD_W'(a_r[i]) * PROD_W'(b_r[j]);
      end
    end

    v[0] <= V_W'(ab[1][2]) - V_W'(ab[2][1]);
    v[1] <= V_W'(ab[2][0]) - V_W'(ab[0][2]);
    v[2] <= V_W'(ab[0][1]) - V_W'(ab[1][0]);
    dd   <= D_W'(ONE_Q28) + D_W'(ab[0][0]) + D_W'(ab[1][1]) + D_W'(ab[2][2]);

    for (int i = 0; i < 3; i++) begin
      vq[i] <= VQ_W'(rnd_shift(v[i], VQ_SHIFT));
    end
    s4.vs0      <= VS_W'(rnd_shift(v[0], VS_SHIFT));
    s4.vs1      <= VS_W'(rnd_shift(v[1], VS_SHIFT));
    s4.vs2      <= VS_W'(rnd_shift(v[2], VS_SHIFT));
    s4.singular <= sing_next;
    d4          <= dd[DU_W-1:0];

    for (int i = 0; i < 3; i++) begin
      sq[i] <= SQ_W'(vq[i]) * SQ_W'(vq[i]);
    end
    xp01 <= SQ_W'(vq[0]) * SQ_W'(vq[1]);
    xp02 <= SQ_W'(vq[0]) * SQ_W'(vq[2]);
    xp12 <= SQ_W'(vq[1]) * SQ_W'(vq[2]);
    s5   <= s4;
    d5   <= d4;

    num[L00] <= -(NUM_W'(sq[1]) + NUM_W'(sq[2]));
    num[L11] <= -(NUM_W'(sq[0]) + NUM_W'(sq[2]));
    num[L22] <= -(NUM_W'(sq[0]) + NUM_W'(sq[1]));
    num[L01] <= NUM_W'(xp01);
    num[L02] <= NUM_W'(xp02);
    num[L12] <= NUM_W'(xp12);
    side     <= s5;
    d        <= d5;
  end

  assign out_valid = vld[FRONT_STAGES-1];

endmodule

`default_nettype wire

### src/avr_div.sv
// Pipelined restoring divider, six lanes sharing one divisor, rounded and clamped quotients.
`default_nettype none

module avr_div import avr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  num_t            num [LANES],
  input  logic [DU_W-1:0] d,
  input  side_t           side_in,
  output logic            out_valid,
  output quo_t            q [LANES],
  output side_t           side_out
);

  logic [DIV_STAGES-1:0] vld;

  logic [REM_W-1:0]     rem [DIV_STEPS][LANES];
  logic [DU_W-1:0]      dr  [DIV_STEPS];
  logic [DIV_STEPS-1:0] qb  [DIV_STEPS+1][LANES];
  logic                 neg [DIV_STEPS+1][LANES];
  side_t                sd  [DIV_STEPS+1];

  logic [MAG_W-1:0] mag_p  [LANES];
  logic [REM_W-1:0] n_prep [LANES];
  logic [REM_W-1:0] rem_nx [DIV_STEPS][LANES];
  logic             bit_nx [DIV_STEPS][LANES];
  logic [Q_W:0]     quo    [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag_p[l]  = num[l][NUM_W-1] ? MAG_W'(-num[l]) : MAG_W'(num[l]);
      n_prep[l] = REM_W'(mag_p[l]) + REM_W'(d >> 1);
    end
  end

  always_comb begin
    logic [REM_W-1:0] trial;
    trial = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      for (int l = 0; l < LANES; l++) begin
        trial = REM_W'(dr[s]) << (DIV_STEPS - 1 - s);
        if (rem[s][l] >= trial) begin
          rem_nx[s][l] = rem[s][l] - trial;
          bit_nx[s][l] = 1'b1;
        end else begin
          rem_nx[s][l] = rem[s][l];
          bit_nx[s][l] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (qb[DIV_STEPS][l][DIV_STEPS-1]) begin
        quo[l] = {1'b0, {Q_W{1'b1}}};
      end else begin
        quo[l] = {1'b0, qb[DIV_STEPS][l][Q_W-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DIV_STAGES-2:0], in_valid};
    end

    for (int l = 0; l < LANES; l++) begin
      rem[0][l] <= n_prep[l];
      neg[0][l] <= num[l][NUM_W-1];
      qb[0][l]  <= '0;
    end
    dr[0] <= d;
    sd[0] <= side_in;

    for (int s = 0; s < DIV_STEPS; s++) begin
      sd[s+1] <= sd[s];
      for (int l = 0; l < LANES; l++) begin
        qb[s+1][l]  <= {qb[s][l][DIV_STEPS-2:0], bit_nx[s][l]};
        neg[s+1][l] <= neg[s][l];
      end
      if (s < DIV_STEPS - 1) begin
        dr[s+1] <= dr[s];
        for (int l = 0; l < LANES; l++) begin
          rem[s+1][l] <= rem_nx[s][l];
        end
      end
    end

    for (int l = 0; l < LANES; l++) begin
      q[l] <= neg[DIV_STEPS][l] ? -$signed(quo[l]) : $signed(quo[l]);
    end
    side_out <= sd[DIV_STEPS];
  end

  assign out_valid = vld[DIV_STAGES-1];

endmodule

`default_nettype wire

### sim/avr_checker.sv
// Checker that predicts each rotation matrix of the alignment block and compares every result.
`timescale 1ns / 1ps

module avr_checker import avr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  q14_t             from_x,
  input  q14_t             from_y,
  input  q14_t             from_z,
  input  q14_t             to_x,
  input  q14_t             to_y,
  input  q14_t             to_z,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_data,
  input  logic             done,
  input  q14_t             m00,
  input  q14_t             m01,
  input  q14_t             m02,
  input  q14_t             m10,
  input  q14_t             m11,
  input  q14_t             m12,
  input  q14_t             m20,
  input  q14_t             m21,
  input  q14_t             m22,
  input  logic             singular,
  output int               fail_count,
  output int               pending
);

  localparam int SKEW_SHIFT = FRAC_W;
  localparam int QUAD_SHIFT = 7;

  typedef struct packed {
    logic [8:0][OUT_W-1:0] m;
    logic                  singular;
  } rot_t;

  rot_t             expected_rot [$];
  logic [THR_W-1:0] thr_q;
  rot_t             got;
  rot_t             want;
  int               errs;
  int               k;
  string            entry_name [9] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                                       "m20", "m21", "m22"};

  function automatic longint round_away(longint x, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (x >= 0) return (x + half) >>> s;
    return -((-x + half) >>> s);
  endfunction

  function automatic rot_t rotation_of(q14_t fx, q14_t fy, q14_t fz,
                                       q14_t tx, q14_t ty, q14_t tz,
                                       logic [THR_W-1:0] thr);
    longint a [3];
    longint b [3];
    longint v [3];
    longint vs [3];
    longint vq [3];
    longint c, d, norm2, num, e, sk;
    rot_t   r;
    a[0] = fx; a[1] = fy; a[2] = fz;
    b[0] = tx; b[1] = ty; b[2] = tz;
    v[0] = a[1] * b[2] - a[2] * b[1];
    v[1] = a[2] * b[0] - a[0] * b[2];
    v[2] = a[0] * b[1] - a[1] * b[0];
    c = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    d = longint'(ONE_Q28) + c;
    r = '0;
    if (d <= 0 || d < (longint'(thr) << FRAC_W)) begin
      for (int i = 0; i < 3; i++) r.m[i * 4] = OUT_W'(ONE_Q14);
      r.singular = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      vs[i] = round_away(v[i], SKEW_SHIFT);
      vq[i] = round_away(v[i], QUAD_SHIFT);
    end
    norm2 = vq[0] * vq[0] + vq[1] * vq[1] + vq[2] * vq[2];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        case (i * 3 + j)
          1: sk = -vs[2];
          2: sk = vs[1];
          3: sk = vs[2];
          5: sk = -vs[0];
          6: sk = -vs[1];
          7: sk = vs[0];
          default: sk = 0;
        endcase
        num = vq[i] * vq[j];
        if (i == j) num = num - norm2;
        if (num >= 0) e = (num + d / 2) / d;
        else e = -((-num + d / 2) / d);
        e = e + sk;
        if (i == j) e = e + ONE_Q14;
        if (e > 32767) e = 32767;
        else if (e < -32768) e = -32768;
        r.m[i * 3 + j] = e[OUT_W-1:0];
      end
    end
    r.singular = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    errs = 0;
    if (rst) begin
      thr_q <= THR_RESET;
      expected_rot.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) thr_q <= cfg_data;
      if (start && !busy)
        expected_rot.push_back(rotation_of(from_x, from_y, from_z, to_x, to_y, to_z, thr_q));
      if (done) begin
        got.m[0] = m00; got.m[1] = m01; got.m[2] = m02;
        got.m[3] = m10; got.m[4] = m11; got.m[5] = m12;
        got.m[6] = m20; got.m[7] = m21; got.m[8] = m22;
        got.singular = singular;
        if (expected_rot.size() == 0) begin
          $error("matrix result with no item waiting");
          errs++;
        end else begin
          want = expected_rot.pop_front();
          for (k = 0; k < 9; k++) begin
            if (got.m[k] !== want.m[k]) begin
              $error("%s mismatch: expected %0d, got %0d", entry_name[k],
                     $signed(want.m[k]), $signed(got.m[k]));
              errs++;
            end
          end
          if (got.singular !== want.singular) begin
            $error("singular mismatch: expected %0d, got %0d", want.singular, got.singular);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= expected_rot.size();
  end

endmodule

### sim/tb_top.sv
// Testbench top for the vector alignment rotation: drives items and configuration, gives the verdict.
`timescale 1ns / 1ps

module tb_top;
  import avr_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN         = LATENCY + 8;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 115;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  q14_t             from_x = '0;
  q14_t             from_y = '0;
  q14_t             from_z = '0;
  q14_t             to_x = '0;
  q14_t             to_y = '0;
  q14_t             to_z = '0;
  logic             cfg_we = 1'b0;
  logic [THR_W-1:0] cfg_data = '0;
  logic             done;
  q14_t             m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic             singular;
  int               fail_count;
  int               pending;
  int               quiet = 0;
  bit               no_idle = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  align_vector_rotation uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .from_x(from_x), .from_y(from_y), .from_z(from_z),
    .to_x(to_x), .to_y(to_y), .to_z(to_z),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .done(done),
    .m00(m00), .m01(m01), .m02(m02),
    .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22),
    .singular(singular)
  );

  avr_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .from_x(from_x), .from_y(from_y), .from_z(from_z),
    .to_x(to_x), .to_y(to_y), .to_z(to_z),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .done(done),
    .m00(m00), .m01(m01), .m02(m02),
    .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22),
    .singular(singular),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic real uni();
    return ($urandom_range(0, 2000000) / 1000000.0) - 1.0;
  endfunction

  function automatic q14_t to_q14(real r);
    int n;
    n = $rtoi(r * 16384.0 + ((r >= 0.0) ? 0.5 : -0.5));
    if (n > ONE_Q14) n = ONE_Q14;
    if (n < -ONE_Q14) n = -ONE_Q14;
    return n[IN_W-1:0];
  endfunction

  task automatic unit_vec(output real x, output real y, output real z);
    real n;
    do begin
      x = uni();
      y = uni();
      z = uni();
      n = x * x + y * y + z * z;
    end while (n < 0.01 || n > 1.0);
    n = $sqrt(n);
    x = x / n;
    y = y / n;
    z = z / n;
  endtask

  // Called at a rising edge; returns at the edge that accepts the item.
  task automatic issue(input q14_t fx, input q14_t fy, input q14_t fz,
                       input q14_t tx, input q14_t ty, input q14_t tz, input int gap);
    logic held;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    from_x <= fx; from_y <= fy; from_z <= fz;
    to_x <= tx; to_y <= ty; to_z <= tz;
    start <= 1'b1;
    do begin
      @(negedge clk);
      held = busy;
      @(posedge clk);
    end while (held);
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] val);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    real  ax, ay, az, bx, by, bz, eps, n;
    int   pick;
    q14_t f [6];
    pick = $urandom_range(0, 99);
    unit_vec(ax, ay, az);
    eps = ($urandom_range(0, 3) == 0) ? 0.0 : 1.0 / (1 << $urandom_range(2, 14));
    if (pick < 55) begin
      unit_vec(bx, by, bz);
    end else if (pick < 75) begin
      bx = -ax + eps * uni();
      by = -ay + eps * uni();
      bz = -az + eps * uni();
    end else begin
      bx = ax + eps * uni();
      by = ay + eps * uni();
      bz = az + eps * uni();
    end
    if (pick >= 55 && pick < 82) begin
      n = $sqrt(bx * bx + by * by + bz * bz);
      if (n > 0.0) begin
        bx = bx / n;
        by = by / n;
        bz = bz / n;
      end
    end
    f[0] = to_q14(ax); f[1] = to_q14(ay); f[2] = to_q14(az);
    f[3] = to_q14(bx); f[4] = to_q14(by); f[5] = to_q14(bz);
    if (pick >= 82 && pick < 91) begin
      for (int i = 0; i < 6; i++) f[i] = IN_W'(int'($urandom_range(0, 32768)) - ONE_Q14);
    end else if (pick >= 91) begin
      for (int i = 0; i < 6; i++) f[i] = IN_W'($urandom);
    end
    issue(f[0], f[1], f[2], f[3], f[4], f[5], draw_gap());
  endtask

  initial begin
    logic [THR_W-1:0] thr;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset threshold, including both sides of its boundary.
    issue(0, 0, 0, 0, 0, 0, 0);
    issue(16384, 0, 0, 16384, 0, 0, 0);
    issue(16384, 0, 0, 0, 16384, 0, draw_gap());
    issue(16384, 0, 0, 0, 0, 16384, 0);
    issue(0, 16384, 0, 16384, 0, 0, draw_gap());
    issue(0, 0, 16384, 0, -16384, 0, 0);
    issue(16384, 0, 0, -16384, 0, 0, draw_gap());
    issue(16384, 0, 0, -16368, 600, 0, 0);
    issue(16384, 0, 0, -16369, 600, 0, 0);
    issue(-16384, 0, 0, 0, 0, -16384, draw_gap());
    issue(9459, 9459, 9459, -9459, 9459, 9459, 0);
    issue(32767, 32767, 32767, -32768, -32768, -32768, 0);
    issue(32767, 0, 0, 0, 32767, 0, draw_gap());
    issue(-32768, -32768, 0, -32768, 32767, 0, 0);
    issue(16384, 16384, 16384, 16384, 16384, 16384, 0);
    issue(-16384, -16384, -16384, 16384, -16384, 16384, draw_gap());
    issue(1, 0, 0, 0, 1, 0, 0);
    issue(-1, -1, -1, 1, 1, 1, 0);
    issue(-32768, 0, 0, 32767, 0, 0, draw_gap());

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: thr = '0;
        1: thr = THR_W'(ONE_Q14);
        2: thr = '1;
        3: thr = THR_W'(1);
        4: thr = THR_W'($urandom_range(0, ONE_Q14));
        5: thr = THR_W'($urandom);
        default: thr = THR_RESET;
      endcase
      set_threshold(thr);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
        random_item();
      end
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
